>>> hw/rtl/wavau_pkg.sv
package wavau_pkg;

  localparam logic [4:0] P_SIG       = 5'd0;
  localparam logic [4:0] P_RIFF_LEN  = 5'd1;
  localparam logic [4:0] P_WAVE_TAG  = 5'd2;
  localparam logic [4:0] P_CHUNK_ID  = 5'd3;
  localparam logic [4:0] P_LEN_FMT   = 5'd4;
  localparam logic [4:0] P_LEN_DATA  = 5'd5;
  localparam logic [4:0] P_LEN_OTHER = 5'd6;
  localparam logic [4:0] P_FMT_TAG   = 5'd7;
  localparam logic [4:0] P_FMT_CH    = 5'd8;
  localparam logic [4:0] P_FMT_RATE  = 5'd9;
  localparam logic [4:0] P_FMT_BRATE = 5'd10;
  localparam logic [4:0] P_FMT_ALIGN = 5'd11;
  localparam logic [4:0] P_FMT_BITS  = 5'd12;
  localparam logic [4:0] P_SKIP      = 5'd13;
  localparam logic [4:0] P_PAD       = 5'd14;
  localparam logic [4:0] P_DATA      = 5'd15;
  localparam logic [4:0] P_AU_OFF    = 5'd16;
  localparam logic [4:0] P_AU_LEN    = 5'd17;
  localparam logic [4:0] P_AU_ENC    = 5'd18;
  localparam logic [4:0] P_AU_RATE   = 5'd19;
  localparam logic [4:0] P_AU_CH     = 5'd20;
  localparam logic [4:0] P_AU_SKIP   = 5'd21;
  localparam logic [4:0] P_AU_DATA   = 5'd22;
  localparam logic [4:0] P_DONE      = 5'd23;

  localparam logic [2:0] C_COPY     = 3'd0;
  localparam logic [2:0] C_PCM16_LE = 3'd1;
  localparam logic [2:0] C_PCM16_BE = 3'd2;
  localparam logic [2:0] C_FLIP8    = 3'd3;
  localparam logic [2:0] C_MULAW    = 3'd4;
  localparam logic [2:0] C_ALAW     = 3'd5;
  localparam logic [2:0] C_BAD      = 3'd6;

  localparam logic [1:0] K_DATA  = 2'd0;
  localparam logic [1:0] K_END   = 2'd1;
  localparam logic [1:0] K_ERROR = 2'd2;

  localparam logic [2:0] S_OK        = 3'd0;
  localparam logic [2:0] S_UNKNOWN   = 3'd1;
  localparam logic [2:0] S_NOT_WAVE  = 3'd2;
  localparam logic [2:0] S_SHORT_FMT = 3'd3;
  localparam logic [2:0] S_UNSUP     = 3'd4;
  localparam logic [2:0] S_NO_FMT    = 3'd5;
  localparam logic [2:0] S_TRUNC     = 3'd6;
  localparam logic [2:0] S_BAD_AU    = 3'd7;

  localparam logic [31:0] SIG_RIFF = 32'h52494646;
  localparam logic [31:0] SIG_AU   = 32'h2E736E64;
  localparam logic [31:0] SIG_WAVE = 32'h57415645;
  localparam logic [31:0] SIG_FMT  = 32'h666d7420;
  localparam logic [31:0] SIG_DATA = 32'h64617461;
  localparam logic [31:0] AU_HDR_LEN = 32'd24;
  localparam logic [31:0] AU_ENC_ALAW = 32'd27;

  localparam logic [7:0] ALAW_XOR = 8'h55;
  localparam logic [8:0] ALAW_BIAS = 9'h108;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic        last;
  } res_t;

  // One accepted byte yields up to three results.
  typedef struct packed {
    logic [1:0]  cnt;
    res_t [2:0]  res;
    logic [15:0] channels;
    logic [12:0] bytes_per_channel;
    logic [31:0] sample_rate;
    logic [31:0] data_length;
  } batch_t;

  function automatic logic [15:0] mu_base(input logic [2:0] ex);
    unique case (ex)
      3'd0: mu_base = 16'd0;
      3'd1: mu_base = 16'd132;
      3'd2: mu_base = 16'd396;
      3'd3: mu_base = 16'd924;
      3'd4: mu_base = 16'd1980;
      3'd5: mu_base = 16'd4092;
      3'd6: mu_base = 16'd8316;
      default: mu_base = 16'd16764;
    endcase
  endfunction

endpackage

>>> hw/rtl/wavau_expand.sv
module wavau_expand
  import wavau_pkg::*;
(
  input  logic [7:0]  code,
  input  logic        is_mulaw,
  output logic [15:0] value
);

  logic [7:0]  m;
  logic [2:0]  ex;
  logic [15:0] mu_v;
  logic [7:0]  a;
  logic [2:0]  seg;
  logic [15:0] t;
  logic [15:0] al_v;

  always_comb begin
    m    = ~code;
    ex   = m[6:4];
    mu_v = mu_base(ex) + (16'({m[3:0]}) << (5'(ex) + 5'd3));
    if (m[7]) mu_v = 16'd0 - mu_v;
    a   = code ^ ALAW_XOR;
    seg = a[6:4];
    t   = {8'd0, a[3:0], 4'd0};
    if (seg == 3'd0) t = t + 16'd8;
    else t = (t + 16'(ALAW_BIAS)) << (seg - 3'd1);
    al_v  = a[7] ? t : 16'd0 - t;
    value = is_mulaw ? mu_v : al_v;
  end

endmodule

>>> hw/rtl/wavau_core.sv
module wavau_core
  import wavau_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] b,
  input  logic       at_end,
  input  logic       le,
  output batch_t     batch
);

  logic [4:0]  phase_r, phase_nxt;
  logic [2:0]  fbs_r, fbs_nxt;
  logic [31:0] fs_r, fs_nxt;
  logic [31:0] left_r, left_nxt;
  logic        odd_r, odd_nxt;
  logic        fmt_r, fmt_nxt;
  logic [2:0]  codec_r, codec_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] off_r, off_nxt;
  logic        unk_r, unk_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        hv_r, hv_nxt;
  logic [31:0] cnt_r, cnt_nxt;

  logic [15:0] xv;
  logic        mu_sel;

  assign mu_sel = (codec_r == C_MULAW);

  wavau_expand u_expand (
    .code     (b),
    .is_mulaw (mu_sel),
    .value    (xv)
  );

  always_comb begin
    logic [31:0] fld;
    logic [2:0]  nfb;
    logic        done4b, done4l, done2l;
    logic [1:0]  n;
    logic        fin;
    logic [31:0] v;

    phase_nxt = phase_r; fbs_nxt = fbs_r; fs_nxt = fs_r; left_nxt = left_r;
    odd_nxt = odd_r; fmt_nxt = fmt_r; codec_nxt = codec_r; ch_nxt = ch_r;
    bits_nxt = bits_r; rate_nxt = rate_r; off_nxt = off_r; unk_nxt = unk_r;
    held_nxt = held_r; hv_nxt = hv_r; cnt_nxt = cnt_r;
    batch = '0;
    n = 2'd0;
    fin = 1'b0;
    v = '0;

    // Field capture: big endian shifts in, little endian places by position.
    fld = (fbs_r == 3'd0) ? 32'd0 : fs_r;
    nfb = fbs_r + 3'd1;
    done4b = (nfb >= 3'd4);
    done4l = done4b;
    done2l = (nfb >= 3'd2);

    unique case (phase_r)
      P_SIG, P_WAVE_TAG, P_CHUNK_ID, P_AU_OFF, P_AU_LEN, P_AU_ENC, P_AU_RATE,
      P_AU_CH: begin
        fs_nxt = {fld[23:0], b};
        fbs_nxt = done4b ? 3'd0 : nfb;
      end
      P_RIFF_LEN, P_LEN_FMT, P_LEN_DATA, P_LEN_OTHER, P_FMT_TAG, P_FMT_CH,
      P_FMT_RATE, P_FMT_BRATE, P_FMT_ALIGN, P_FMT_BITS: begin
        fs_nxt = fld | (32'(b) << {fbs_r[1:0], 3'b000});
        if (phase_r == P_FMT_TAG || phase_r == P_FMT_CH || phase_r == P_FMT_ALIGN ||
            phase_r == P_FMT_BITS)
          fbs_nxt = done2l ? 3'd0 : nfb;
        else
          fbs_nxt = done4l ? 3'd0 : nfb;
      end
      default: ;
    endcase
    v = fs_nxt;

    unique case (phase_r)
      P_SIG: if (done4b) begin
        if (v == SIG_RIFF) phase_nxt = P_RIFF_LEN;
        else if (v == SIG_AU) phase_nxt = P_AU_OFF;
        else begin
          batch.res[n] = '{K_ERROR, 8'd0, S_UNKNOWN, 1'b1}; n = n + 2'd1;
          phase_nxt = P_DONE;
        end
      end
      P_RIFF_LEN: if (done4l) phase_nxt = P_WAVE_TAG;
      P_WAVE_TAG: if (done4b) begin
        if (v == SIG_WAVE) phase_nxt = P_CHUNK_ID;
        else begin
          batch.res[n] = '{K_ERROR, 8'd0, S_NOT_WAVE, 1'b1}; n = n + 2'd1;
          phase_nxt = P_DONE;
        end
      end
      P_CHUNK_ID: if (done4b)
        phase_nxt = (v == SIG_FMT) ? P_LEN_FMT : (v == SIG_DATA) ? P_LEN_DATA : P_LEN_OTHER;
      P_LEN_FMT, P_LEN_DATA, P_LEN_OTHER: if (done4l) begin
        odd_nxt = v[0];
        if (phase_r == P_LEN_FMT) begin
          if (v < 32'd16) begin
            batch.res[n] = '{K_ERROR, 8'd0, S_SHORT_FMT, 1'b1}; n = n + 2'd1;
            phase_nxt = P_DONE;
          end else begin
            left_nxt = v - 32'd16; phase_nxt = P_FMT_TAG;
          end
        end else if (phase_r == P_LEN_DATA) begin
          if (!fmt_r) begin
            batch.res[n] = '{K_ERROR, 8'd0, S_NO_FMT, 1'b1}; n = n + 2'd1;
            phase_nxt = P_DONE;
          end else if (v == 32'd0) fin = 1'b1;
          else begin
            left_nxt = v; phase_nxt = P_DATA;
          end
        end else begin
          left_nxt = v;
          if (v == 32'd0) phase_nxt = v[0] ? P_PAD : P_CHUNK_ID;
          else phase_nxt = P_SKIP;
        end
      end
      P_FMT_TAG: if (done2l) begin
        codec_nxt = (v == 32'd1) ? C_PCM16_LE : (v == 32'd7) ? C_MULAW : C_BAD;
        phase_nxt = P_FMT_CH;
      end
      P_FMT_CH: if (done2l) begin
        ch_nxt = v[15:0]; phase_nxt = P_FMT_RATE;
      end
      P_FMT_RATE: if (done4l) begin
        rate_nxt = v; phase_nxt = P_FMT_BRATE;
      end
      P_FMT_BRATE: if (done4l) phase_nxt = P_FMT_ALIGN;
      P_FMT_ALIGN: if (done2l) phase_nxt = P_FMT_BITS;
      P_FMT_BITS: if (done2l) begin
        bits_nxt = v[15:0];
        if (codec_r == C_BAD) begin
          batch.res[n] = '{K_ERROR, 8'd0, S_UNSUP, 1'b1}; n = n + 2'd1;
          phase_nxt = P_DONE;
        end else begin
          if (codec_r == C_PCM16_LE && v[15:0] == 16'd8) codec_nxt = C_COPY;
          if (codec_r == C_MULAW) bits_nxt = {v[14:0], 1'b0};
          fmt_nxt = 1'b1;
          if (left_r == 32'd0) phase_nxt = odd_r ? P_PAD : P_CHUNK_ID;
          else phase_nxt = P_SKIP;
        end
      end
      P_SKIP: begin
        left_nxt = left_r - 32'd1;
        if (left_nxt == 32'd0) phase_nxt = odd_r ? P_PAD : P_CHUNK_ID;
      end
      P_PAD: phase_nxt = P_CHUNK_ID;
      P_AU_OFF: if (done4b) begin
        off_nxt = v; phase_nxt = P_AU_LEN;
      end
      P_AU_LEN: if (done4b) begin
        unk_nxt = (v == 32'hFFFFFFFF);
        left_nxt = (v == 32'hFFFFFFFF) ? 32'd0 : v;
        phase_nxt = P_AU_ENC;
      end
      P_AU_ENC: if (done4b) begin
        codec_nxt = (v == 32'd1) ? C_MULAW : (v == 32'd2) ? C_FLIP8 :
                    (v == 32'd3) ? C_PCM16_BE : (v == AU_ENC_ALAW) ? C_ALAW : C_BAD;
        phase_nxt = P_AU_RATE;
      end
      P_AU_RATE: if (done4b) begin
        rate_nxt = v; phase_nxt = P_AU_CH;
      end
      P_AU_CH: if (done4b) begin
        if (off_r < AU_HDR_LEN || off_r[31] || rate_r == 32'd0 || rate_r[31] ||
            v == 32'd0 || v[31] || (!unk_r && left_r == 32'd0)) begin
          batch.res[n] = '{K_ERROR, 8'd0, S_BAD_AU, 1'b1}; n = n + 2'd1;
          phase_nxt = P_DONE;
        end else if (codec_r == C_BAD) begin
          batch.res[n] = '{K_ERROR, 8'd0, S_UNSUP, 1'b1}; n = n + 2'd1;
          phase_nxt = P_DONE;
        end else begin
          ch_nxt = (v > 32'd65535) ? 16'hFFFF : v[15:0];
          bits_nxt = (codec_r == C_FLIP8) ? 16'd8 : 16'd16;
          off_nxt = off_r - AU_HDR_LEN;
          phase_nxt = (off_nxt == 32'd0) ? P_AU_DATA : P_AU_SKIP;
        end
      end
      P_AU_SKIP: begin
        off_nxt = off_r - 32'd1;
        if (off_nxt == 32'd0) phase_nxt = P_AU_DATA;
      end
      P_DATA, P_AU_DATA: begin
        unique case (codec_r)
          C_FLIP8: begin
            batch.res[n] = '{K_DATA, b ^ 8'h80, S_OK, 1'b0}; n = n + 2'd1;
          end
          C_PCM16_LE, C_PCM16_BE: begin
            if ((codec_r == C_PCM16_LE) == le) begin
              batch.res[n] = '{K_DATA, b, S_OK, 1'b0}; n = n + 2'd1;
            end else if (!hv_r) begin
              held_nxt = b; hv_nxt = 1'b1;
            end else begin
              batch.res[n] = '{K_DATA, b, S_OK, 1'b0}; n = n + 2'd1;
              batch.res[n] = '{K_DATA, held_r, S_OK, 1'b0}; n = n + 2'd1;
              hv_nxt = 1'b0;
            end
          end
          C_MULAW, C_ALAW: begin
            batch.res[n] = '{K_DATA, le ? xv[7:0] : xv[15:8], S_OK, 1'b0}; n = n + 2'd1;
            batch.res[n] = '{K_DATA, le ? xv[15:8] : xv[7:0], S_OK, 1'b0}; n = n + 2'd1;
          end
          default: begin
            batch.res[n] = '{K_DATA, b, S_OK, 1'b0}; n = n + 2'd1;
          end
        endcase
        if (phase_r == P_AU_DATA && unk_r) begin
          if (at_end) fin = 1'b1;
        end else begin
          left_nxt = left_r - 32'd1;
          if (left_nxt == 32'd0) fin = 1'b1;
        end
      end
      default: ;
    endcase

    // A held swap byte at the end goes out unchanged before the report.
    if (fin) begin
      if (hv_nxt) begin
        batch.res[n] = '{K_DATA, held_nxt, S_OK, 1'b0}; n = n + 2'd1;
        hv_nxt = 1'b0;
      end
      batch.res[n] = '{K_END, 8'd0, S_OK, 1'b1}; n = n + 2'd1;
      phase_nxt = P_DONE;
    end

    // Saturating count of emitted data bytes (at most three per item).
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n && batch.res[i].kind == K_DATA && cnt_nxt != 32'hFFFFFFFF)
        cnt_nxt = cnt_nxt + 32'd1;
    end
    batch.channels = ch_nxt;
    batch.bytes_per_channel = bits_nxt[15:3];
    batch.sample_rate = rate_nxt;
    batch.data_length = cnt_nxt;

    if (at_end) begin
      if (phase_nxt != P_DONE) begin
        batch.res[n] = '{K_ERROR, 8'd0, S_TRUNC, 1'b1}; n = n + 2'd1;
      end
      phase_nxt = P_SIG; fbs_nxt = '0; fs_nxt = '0; left_nxt = '0; odd_nxt = 1'b0;
      fmt_nxt = 1'b0; codec_nxt = C_COPY; ch_nxt = '0; bits_nxt = '0; rate_nxt = '0;
      off_nxt = '0; unk_nxt = 1'b0; held_nxt = '0; hv_nxt = 1'b0; cnt_nxt = '0;
    end
    batch.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_SIG; fbs_r <= '0; fs_r <= '0; left_r <= '0; odd_r <= 1'b0;
      fmt_r <= 1'b0; codec_r <= C_COPY; ch_r <= '0; bits_r <= '0; rate_r <= '0;
      off_r <= '0; unk_r <= 1'b0; held_r <= '0; hv_r <= 1'b0; cnt_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; fbs_r <= fbs_nxt; fs_r <= fs_nxt; left_r <= left_nxt;
      odd_r <= odd_nxt; fmt_r <= fmt_nxt; codec_r <= codec_nxt; ch_r <= ch_nxt;
      bits_r <= bits_nxt; rate_r <= rate_nxt; off_r <= off_nxt; unk_r <= unk_nxt;
      held_r <= held_nxt; hv_r <= hv_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/wav_au_container_sample_decoder.sv
// Byte-stream parser for RIFF WAVE and AU sound files with mu-law and A-law
// expansion. One item is one file byte; in_last marks the final byte and
// restarts the parser after it. Each byte is parsed in the cycle it is taken
// from the input register stage; its up to three results are queued in a
// result buffer and drained one per cycle while out_ready is high. The block
// takes a new byte every cycle while the output is taken every cycle and a
// byte makes at most one result; expanding codecs (two results per byte) take
// a new byte as the second result drains, limited by the single output port.
// cfg_little_endian_output selects host byte order (1 little endian, reset 1).
module wav_au_container_sample_decoder
  import wavau_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        cfg_we,
  input  logic        cfg_little_endian_output,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [2:0]  out_status,
  output logic [15:0] out_channels,
  output logic [12:0] out_bytes_per_channel,
  output logic [31:0] out_sample_rate,
  output logic [31:0] out_data_length,
  output logic        out_last
);

  logic        le_r;
  logic        iv_r;
  logic [7:0]  ib_r;
  logic        il_r;
  batch_t      batch;
  logic        step;

  // Result buffer: up to three pending results with their report fields.
  res_t [2:0]  q_r;
  logic [1:0]  qn_r;
  logic [1:0]  qh_r;
  logic [15:0] ch_r;
  logic [12:0] bpc_r;
  logic [31:0] sr_r;
  logic [31:0] dl_r;
  logic        pop;
  logic [1:0]  left;

  assign pop   = out_valid && out_ready;
  assign left  = qn_r - 2'(pop);
  assign step  = iv_r && (left == 2'd0);
  assign in_ready = !iv_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) le_r <= 1'b1;
    else if (cfg_we) le_r <= cfg_little_endian_output;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_ready) begin
      iv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ib_r <= in_byte;
      il_r <= in_last;
    end
  end

  wavau_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .b      (ib_r),
    .at_end (il_r),
    .le     (le_r),
    .batch  (batch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qn_r <= '0;
      qh_r <= '0;
    end else if (step) begin
      qn_r <= batch.cnt;
      qh_r <= '0;
    end else if (pop) begin
      qn_r <= qn_r - 2'd1;
      qh_r <= qh_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      q_r   <= batch.res;
      ch_r  <= batch.channels;
      bpc_r <= batch.bytes_per_channel;
      sr_r  <= batch.sample_rate;
      dl_r  <= batch.data_length;
    end
  end

  always_comb begin
    res_t r;
    r = q_r[qh_r];
    out_valid     = (qn_r != 2'd0);
    out_kind      = r.kind;
    out_data_byte = (r.kind == K_DATA) ? r.data_byte : 8'd0;
    out_status    = (r.kind == K_ERROR) ? r.status : S_OK;
    out_last      = r.last;
    out_channels          = (r.kind == K_END) ? ch_r : 16'd0;
    out_bytes_per_channel = (r.kind == K_END) ? bpc_r : 13'd0;
    out_sample_rate       = (r.kind == K_END) ? sr_r : 32'd0;
    out_data_length       = (r.kind == K_END) ? dl_r : 32'd0;
  end

`ifndef SYNTHESIS
  a_no_step_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (qn_r != 2'd0 && !pop) |-> !step) else $error("parser stepped over pending results");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (qn_r != 2'd3 || qh_r == 2'd0)) else $error("result buffer index overrun");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (qn_r == 2'd1)) else $error("result after final one");
`endif

endmodule

>>> tb/sv/tb_wav_au_container_sample_decoder.sv
`timescale 1ns / 100ps

module tb_wav_au_container_sample_decoder;
  import wavau_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [15:0] channels;
    logic [12:0] bytes_per_channel;
    logic [31:0] sample_rate;
    logic [31:0] data_length;
    logic        last;
  } decoded_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } file_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        cfg_we;
  logic        cfg_little_endian_output;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [2:0]  out_status;
  logic [15:0] out_channels;
  logic [12:0] out_bytes_per_channel;
  logic [31:0] out_sample_rate;
  logic [31:0] out_data_length;
  logic        out_last;

  wav_au_container_sample_decoder dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_byte                  (in_byte),
    .in_last                  (in_last),
    .cfg_we                   (cfg_we),
    .cfg_little_endian_output (cfg_little_endian_output),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_kind                 (out_kind),
    .out_data_byte            (out_data_byte),
    .out_status               (out_status),
    .out_channels             (out_channels),
    .out_bytes_per_channel    (out_bytes_per_channel),
    .out_sample_rate          (out_sample_rate),
    .out_data_length          (out_data_length),
    .out_last                 (out_last)
  );

  file_byte_t pending_bytes[$];
  logic [7:0] file_buf[$];
  decoded_t   expected_results[$];
  int         error_count = 0;
  int         bytes_sent = 0;
  int         results_checked = 0;
  int         files_built = 0;

  // Parser state mirrored for prediction.
  logic [4:0]  pr_phase;
  logic [2:0]  pr_field_cnt;
  logic [31:0] pr_field;
  logic [31:0] pr_left;
  logic        pr_odd;
  logic        pr_fmt_seen;
  logic [2:0]  pr_codec;
  logic [15:0] pr_chans;
  logic [15:0] pr_bits;
  logic [31:0] pr_rate;
  logic [31:0] pr_au_off;
  logic        pr_au_unknown;
  logic [7:0]  pr_held;
  logic        pr_held_valid;
  logic [31:0] pr_emitted;
  logic        pr_little;

  logic [15:0] mu_segment_base[8] = '{16'd0, 16'd132, 16'd396, 16'd924, 16'd1980,
                                      16'd4092, 16'd8316, 16'd16764};

  function automatic void clear_parser();
    pr_phase = P_SIG; pr_field_cnt = 0; pr_field = 0; pr_left = 0; pr_odd = 0;
    pr_fmt_seen = 0; pr_codec = C_COPY; pr_chans = 0; pr_bits = 0; pr_rate = 0;
    pr_au_off = 0; pr_au_unknown = 0; pr_held = 0; pr_held_valid = 0; pr_emitted = 0;
  endfunction

  function automatic void add_result(logic [1:0] k, logic [7:0] b, logic [2:0] st,
                                     logic lst);
    decoded_t r;
    r = '{k, b, st, 16'd0, 13'd0, 32'd0, 32'd0, lst};
    if (k == K_END) begin
      r.channels = pr_chans;
      r.bytes_per_channel = pr_bits[15:3];
      r.sample_rate = pr_rate;
      r.data_length = pr_emitted;
    end
    expected_results.push_back(r);
  endfunction

  function automatic void add_sample(logic [7:0] b);
    if (pr_emitted != 32'hFFFFFFFF) pr_emitted++;
    add_result(K_DATA, b, S_OK, 1'b0);
  endfunction

  function automatic void add_error(logic [2:0] st);
    pr_phase = P_DONE;
    add_result(K_ERROR, 8'd0, st, 1'b1);
  endfunction

  function automatic void finish_file();
    if (pr_held_valid) begin
      add_sample(pr_held);
      pr_held_valid = 0;
    end
    pr_phase = P_DONE;
    add_result(K_END, 8'd0, S_OK, 1'b1);
  endfunction

  // Gathers a header field byte by byte; returns 1 once it is complete.
  function automatic bit gather(logic [7:0] b, bit big, int nbytes);
    if (pr_field_cnt == 0) pr_field = 0;
    if (big) pr_field = {pr_field[23:0], b};
    else pr_field = pr_field | (32'(b) << (8 * pr_field_cnt[1:0]));
    pr_field_cnt++;
    if (pr_field_cnt >= nbytes) begin
      pr_field_cnt = 0;
      return 1;
    end
    return 0;
  endfunction

  function automatic logic [15:0] expand_mulaw(logic [7:0] b);
    logic [7:0]  m;
    logic [15:0] v;
    m = ~b;
    v = mu_segment_base[m[6:4]] + (16'(m[3:0]) << (m[6:4] + 3));
    return m[7] ? 16'(-v) : v;
  endfunction

  function automatic logic [15:0] expand_alaw(logic [7:0] b);
    logic [7:0]  a;
    logic [31:0] t;
    a = b ^ ALAW_XOR;
    t = 32'(a[3:0]) << 4;
    if (a[6:4] == 0) t = t + 8;
    else t = (t + 32'(ALAW_BIAS)) << (a[6:4] - 1);
    return a[7] ? t[15:0] : 16'(-t[15:0]);
  endfunction

  function automatic void decode_sample(logic [7:0] b);
    logic [15:0] v;
    case (pr_codec)
      C_FLIP8: add_sample(b ^ 8'h80);
      C_PCM16_LE, C_PCM16_BE: begin
        if ((pr_codec == C_PCM16_LE) == pr_little) add_sample(b);
        else if (!pr_held_valid) begin
          pr_held = b;
          pr_held_valid = 1;
        end else begin
          add_sample(b);
          pr_held_valid = 0;
          add_sample(pr_held);
        end
      end
      C_MULAW, C_ALAW: begin
        v = (pr_codec == C_MULAW) ? expand_mulaw(b) : expand_alaw(b);
        add_sample(pr_little ? v[7:0] : v[15:8]);
        add_sample(pr_little ? v[15:8] : v[7:0]);
      end
      default: add_sample(b);
    endcase
  endfunction

  function automatic void end_of_skip();
    pr_phase = pr_odd ? P_PAD : P_CHUNK_ID;
  endfunction

  function automatic bit positive_word(logic [31:0] v, logic [31:0] min);
    return v >= min && !v[31];
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic at_end);
    logic [31:0] v;
    case (pr_phase)
      P_SIG: if (gather(b, 1, 4)) begin
        if (pr_field == SIG_RIFF) pr_phase = P_RIFF_LEN;
        else if (pr_field == SIG_AU) pr_phase = P_AU_OFF;
        else add_error(S_UNKNOWN);
      end
      P_RIFF_LEN: if (gather(b, 0, 4)) pr_phase = P_WAVE_TAG;
      P_WAVE_TAG: if (gather(b, 1, 4)) begin
        if (pr_field == SIG_WAVE) pr_phase = P_CHUNK_ID;
        else add_error(S_NOT_WAVE);
      end
      P_CHUNK_ID: if (gather(b, 1, 4)) begin
        pr_phase = pr_field == SIG_FMT ? P_LEN_FMT :
                   pr_field == SIG_DATA ? P_LEN_DATA : P_LEN_OTHER;
      end
      P_LEN_FMT, P_LEN_DATA, P_LEN_OTHER: if (gather(b, 0, 4)) begin
        v = pr_field;
        pr_odd = v[0];
        if (pr_phase == P_LEN_FMT) begin
          if (v < 16) add_error(S_SHORT_FMT);
          else begin
            pr_left = v - 16;
            pr_phase = P_FMT_TAG;
          end
        end else if (pr_phase == P_LEN_DATA) begin
          if (!pr_fmt_seen) add_error(S_NO_FMT);
          else if (v == 0) finish_file();
          else begin
            pr_left = v;
            pr_phase = P_DATA;
          end
        end else begin
          pr_left = v;
          if (v == 0) end_of_skip();
          else pr_phase = P_SKIP;
        end
      end
      P_FMT_TAG: if (gather(b, 0, 2)) begin
        pr_codec = pr_field == 1 ? C_PCM16_LE : pr_field == 7 ? C_MULAW : C_BAD;
        pr_phase = P_FMT_CH;
      end
      P_FMT_CH: if (gather(b, 0, 2)) begin
        pr_chans = pr_field[15:0];
        pr_phase = P_FMT_RATE;
      end
      P_FMT_RATE: if (gather(b, 0, 4)) begin
        pr_rate = pr_field;
        pr_phase = P_FMT_BRATE;
      end
      P_FMT_BRATE: if (gather(b, 0, 4)) pr_phase = P_FMT_ALIGN;
      P_FMT_ALIGN: if (gather(b, 0, 2)) pr_phase = P_FMT_BITS;
      P_FMT_BITS: if (gather(b, 0, 2)) begin
        pr_bits = pr_field[15:0];
        if (pr_codec == C_BAD) add_error(S_UNSUP);
        else begin
          if (pr_codec == C_PCM16_LE && pr_bits == 8) pr_codec = C_COPY;
          if (pr_codec == C_MULAW) pr_bits = {pr_bits[14:0], 1'b0};
          pr_fmt_seen = 1;
          if (pr_left == 0) end_of_skip();
          else pr_phase = P_SKIP;
        end
      end
      P_SKIP: begin
        pr_left--;
        if (pr_left == 0) end_of_skip();
      end
      P_PAD: pr_phase = P_CHUNK_ID;
      P_DATA: begin
        decode_sample(b);
        pr_left--;
        if (pr_left == 0) finish_file();
      end
      P_AU_OFF: if (gather(b, 1, 4)) begin
        pr_au_off = pr_field;
        pr_phase = P_AU_LEN;
      end
      P_AU_LEN: if (gather(b, 1, 4)) begin
        pr_au_unknown = pr_field == 32'hFFFFFFFF;
        pr_left = pr_au_unknown ? 32'd0 : pr_field;
        pr_phase = P_AU_ENC;
      end
      P_AU_ENC: if (gather(b, 1, 4)) begin
        v = pr_field;
        pr_codec = v == 1 ? C_MULAW : v == 2 ? C_FLIP8 : v == 3 ? C_PCM16_BE :
                   v == AU_ENC_ALAW ? C_ALAW : C_BAD;
        pr_phase = P_AU_RATE;
      end
      P_AU_RATE: if (gather(b, 1, 4)) begin
        pr_rate = pr_field;
        pr_phase = P_AU_CH;
      end
      P_AU_CH: if (gather(b, 1, 4)) begin
        v = pr_field;
        if (!positive_word(pr_au_off, AU_HDR_LEN) || !positive_word(pr_rate, 1) ||
            !positive_word(v, 1) || (!pr_au_unknown && pr_left == 0)) begin
          add_error(S_BAD_AU);
        end else if (pr_codec == C_BAD) begin
          add_error(S_UNSUP);
        end else begin
          pr_chans = v > 65535 ? 16'hFFFF : v[15:0];
          pr_bits = pr_codec == C_FLIP8 ? 16'd8 : 16'd16;
          pr_au_off = pr_au_off - AU_HDR_LEN;
          pr_phase = pr_au_off == 0 ? P_AU_DATA : P_AU_SKIP;
        end
      end
      P_AU_SKIP: begin
        pr_au_off--;
        if (pr_au_off == 0) pr_phase = P_AU_DATA;
      end
      P_AU_DATA: begin
        decode_sample(b);
        if (pr_au_unknown) begin
          if (at_end) finish_file();
        end else begin
          pr_left--;
          if (pr_left == 0) finish_file();
        end
      end
      default: ;
    endcase
    if (at_end) begin
      if (pr_phase != P_DONE) add_error(S_TRUNC);
      clear_parser();
    end
  endfunction

  // ---------------- file builders ----------------
  task automatic put_be(logic [31:0] w, int n);
    for (int i = n - 1; i >= 0; i--) file_buf.push_back(w[8*i +: 8]);
  endtask

  task automatic put_le(logic [31:0] w, int n);
    for (int i = 0; i < n; i++) file_buf.push_back(w[8*i +: 8]);
  endtask

  task automatic put_random(int n);
    for (int i = 0; i < n; i++) file_buf.push_back(8'($urandom));
  endtask

  // Moves the built file to the driver queue, cut short or padded now and then.
  task automatic commit_file(bit may_cut);
    int len;
    len = file_buf.size();
    if (may_cut && $urandom_range(0, 99) < 12 && len > 1) len = $urandom_range(1, len - 1);
    else if (may_cut && $urandom_range(0, 99) < 30) begin
      put_random($urandom_range(1, 3));
      len = file_buf.size();
    end
    for (int i = 0; i < len; i++) pending_bytes.push_back('{file_buf[i], i == len - 1});
    file_buf.delete();
    files_built++;
  endtask

  task automatic put_other_chunk();
    int n;
    n = $urandom_range(0, 5);
    put_be(32'h4C495354, 4);
    put_le(n, 4);
    put_random(n + (n % 2));
  endtask

  task automatic build_wav();
    int sel, flen, tag, dlen;
    sel = $urandom_range(0, 99);
    if (sel < 3) put_random(4);
    else put_be(SIG_RIFF, 4);
    put_le($urandom, 4);
    put_be(sel < 6 ? 32'($urandom) : SIG_WAVE, 4);
    repeat ($urandom_range(0, 2)) put_other_chunk();
    if (sel >= 6 && sel < 11) begin
      put_be(SIG_DATA, 4);
      put_le($urandom_range(0, 4), 4);
    end
    flen = (sel >= 11 && sel < 16) ? $urandom_range(0, 15) : 16 + $urandom_range(0, 3);
    put_be(SIG_FMT, 4);
    put_le(flen, 4);
    tag = $urandom_range(0, 99);
    put_le(tag < 45 ? 1 : tag < 88 ? 7 : $urandom, 2);
    put_le($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 2), 2);
    put_le($urandom, 4);
    put_random(6);
    tag = $urandom_range(0, 9);
    put_le(tag < 4 ? 8 : tag < 9 ? 16 : $urandom, 2);
    put_random(flen > 16 ? flen - 16 + (flen % 2) : 0);
    if ($urandom_range(0, 3) == 0) put_other_chunk();
    put_be(SIG_DATA, 4);
    dlen = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 12);
    put_le(dlen, 4);
    put_random(dlen);
    commit_file(1);
  endtask

  task automatic build_au();
    logic [31:0] off, len, enc, rate, chans;
    int sel, ndata;
    sel = $urandom_range(0, 99);
    off = 24 + $urandom_range(0, 4);
    if (sel < 3) off = $urandom_range(0, 23);
    else if (sel < 5) off = 32'h80000000 | $urandom;
    len = $urandom_range(0, 2) == 0 ? 32'hFFFFFFFF : $urandom_range(1, 12);
    if (sel >= 5 && sel < 8) len = 0;
    enc = $urandom_range(0, 3);
    enc = enc == 0 ? 1 : enc == 1 ? 2 : enc == 2 ? 3 : AU_ENC_ALAW;
    if (sel >= 8 && sel < 12) enc = $urandom;
    rate = $urandom_range(1, 32'h7FFFFFFF);
    if (sel >= 12 && sel < 15) rate = sel == 12 ? 0 : 32'h80000000 | $urandom;
    chans = $urandom_range(1, 4);
    if (sel >= 15 && sel < 18) chans = sel == 15 ? 0 : sel == 16 ? 32'hFFFFFFFF : 70000;
    if (sel >= 18 && sel < 21) chans = $urandom_range(65536, 32'h7FFFFFFF);
    put_be(SIG_AU, 4);
    put_be(off, 4);
    put_be(len, 4);
    put_be(enc, 4);
    put_be(rate, 4);
    put_be(chans, 4);
    put_random(off >= 24 && off < 32 ? off - 24 : 2);
    ndata = len == 32'hFFFFFFFF ? $urandom_range(1, 10) : len;
    put_random(ndata);
    commit_file(len != 32'hFFFFFFFF);
  endtask

  // ---------------- clock, reset, limit ----------------
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  // ---------------- driver ----------------
  file_byte_t cur_item;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_byte, in_last);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          cur_item = pending_bytes.pop_front();
          in_byte <= cur_item.b;
          in_last <= cur_item.last;
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // Some bursts run back to back with no gap at all.
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int stall_mode = 0;
  int stall_cnt = 0;

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    decoded_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d data 0x%0h status %0d",
                 out_kind, out_data_byte, out_status);
          error_count++;
        end else begin
          e = expected_results.pop_front();
          check_field("kind", e.kind, out_kind);
          check_field("data_byte", e.data_byte, out_data_byte);
          check_field("status", e.status, out_status);
          check_field("channels", e.channels, out_channels);
          check_field("bytes_per_channel", e.bytes_per_channel, out_bytes_per_channel);
          check_field("sample_rate", e.sample_rate, out_sample_rate);
          check_field("data_length", e.data_length, out_data_length);
          check_field("last", e.last, out_last);
          results_checked++;
        end
      end
      stall_cnt++;
      if (stall_cnt % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 9) < 7;
        2: out_ready <= (stall_cnt % 5) != 0;
        default: out_ready <= (stall_cnt % 8) < 2;
      endcase
    end
  end

  // ---------------- sequence ----------------
  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_byte_order(logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_little_endian_output <= v;
    pr_little = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int random_start;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'd0;
    in_last = 1'b0;
    cfg_we = 1'b0;
    cfg_little_endian_output = 1'b1;
    out_ready = 1'b0;
    pr_little = 1'b1;
    clear_parser();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_byte_order(1'b1);

    // Directed: unknown signature with extreme bytes, a one-byte file, and an
    // AU A-law stream of unknown length running to the final byte.
    file_buf = '{8'hFF, 8'h00, 8'hFF, 8'h00};
    commit_file(0);
    file_buf = '{8'h52};
    commit_file(0);
    put_be(SIG_AU, 4);
    put_be(AU_HDR_LEN, 4);
    put_be(32'hFFFFFFFF, 4);
    put_be(AU_ENC_ALAW, 4);
    put_be(8000, 4);
    put_be(1, 4);
    file_buf.push_back(8'h00);
    file_buf.push_back(8'hFF);
    file_buf.push_back(8'h55);
    file_buf.push_back(8'hD5);
    commit_file(0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_byte_order(ph % 2 == 0 ? 1'b0 : 1'b1);
      random_start = bytes_sent;
      while (pending_bytes.size() + bytes_sent - random_start < 80) begin
        case ($urandom_range(0, 9))
          0: begin
            put_random($urandom_range(1, 6));
            commit_file(0);
          end
          1, 2, 3, 4: build_wav();
          default: build_au();
        endcase
      end
      wait_drained();
    end

    $display("Ran %0d files (%0d bytes) through WAVE and AU parsing in both output orders,",
             files_built, bytes_sent);
    $display("checking %0d results including errors, truncations and G.711 expansion.",
             results_checked);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/wavau_pkg.sv
hw/rtl/wavau_expand.sv
hw/rtl/wavau_core.sv
hw/rtl/wav_au_container_sample_decoder.sv
tb/sv/tb_wav_au_container_sample_decoder.sv
